/* sv/ppi_pkg.sv */
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared constants, reply tables and store access types of the PPI responder.
// ----------------------------------------------------------------------------
`default_nettype none

package ppi_pkg;

    localparam int FRAME_DEPTH  = 64;
    localparam int MAX_IO_BYTES = 8;

    localparam int AW  = $clog2(FRAME_DEPTH);
    localparam int BCW = $clog2(FRAME_DEPTH + 1);

    localparam logic [7:0] BYTE_ACK     = 8'hE5;
    localparam logic [7:0] BYTE_KEY_NEG = 8'hEB;
    localparam logic [7:0] BYTE_KEY_RUN = 8'hBA;
    localparam logic [7:0] BYTE_B6_A    = 8'h6C;
    localparam logic [7:0] BYTE_B6_B    = 8'h7C;
    localparam logic [7:0] BYTE_B8_READ = 8'h01;
    localparam logic [7:0] BYTE_B8_WR   = 8'h07;
    localparam logic [7:0] BYTE_REQ     = 8'h68;
    localparam logic [7:0] BYTE_END     = 8'h16;
    localparam logic [7:0] BYTE_POLL    = 8'h10;

    localparam logic [BCW-1:0] LEN_NEG  = BCW'(8'h15 + 6);
    localparam logic [BCW-1:0] LEN_RUN  = BCW'(8'h21 + 6);
    localparam logic [BCW-1:0] LEN_STOP = BCW'(8'h1D + 6);
    localparam logic [BCW-1:0] LEN_POLL = BCW'(6);

    localparam logic [AW-1:0] IDX_B6  = AW'(6);
    localparam logic [AW-1:0] IDX_B8  = AW'(8);
    localparam logic [AW-1:0] IDX_IMG = AW'(45);

    localparam logic [5:0] READ_SPLICE = 6'd25;
    localparam logic [5:0] READ_SUM    = 6'd39;
    localparam logic [5:0] SUM_FIRST   = 6'd4;
    localparam logic [5:0] SUM_LAST    = 6'd38;

    localparam logic [2:0] RP_NONE      = 3'd0;
    localparam logic [2:0] RP_NEGOTIATE = 3'd1;
    localparam logic [2:0] RP_RUN       = 3'd2;
    localparam logic [2:0] RP_STOP      = 3'd3;
    localparam logic [2:0] RP_READ      = 3'd4;
    localparam logic [2:0] RP_FORCE     = 3'd5;
    localparam logic [2:0] RP_AFTER     = 3'd6;

    localparam logic [3:0] CFG_OUT_COUNT = 4'd0;
    localparam logic [3:0] CFG_IN_COUNT  = 4'd1;

    localparam logic [7:0] TBL_NEG [29] = '{
        8'h68,8'h17,8'h17,8'h68,8'h00,8'h02,8'h08,8'h32,8'h03,8'h00,8'h00,8'hCC,
        8'hC1,8'h00,8'h08,8'h00,8'h00,8'h00,8'h00,8'hF0,8'h01,8'h00,8'h01,8'h00,
        8'h01,8'h00,8'hF0,8'hB7,8'h16};
    localparam logic [7:0] TBL_RUN [22] = '{
        8'h68,8'h10,8'h10,8'h68,8'h00,8'h02,8'h08,8'h32,8'h03,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h01,8'h00,8'h00,8'h00,8'h00,8'h28,8'h68,8'h16};
    localparam logic [7:0] TBL_FORCE [36] = '{
        8'h68,8'h1E,8'h1E,8'h68,8'h01,8'h02,8'h08,8'h32,8'h07,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h0C,8'h00,8'h05,8'h00,8'h01,8'h12,8'h08,8'h12,8'h88,8'h0B,
        8'h01,8'h00,8'h00,8'h00,8'h00,8'hFF,8'h09,8'h00,8'h01,8'hFF,8'h1E,8'h16};
    localparam logic [7:0] TBL_READ [41] = '{
        8'h68,8'h23,8'h23,8'h68,8'h01,8'h02,8'h08,8'h32,8'h03,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h02,8'h00,8'h12,8'h00,8'h00,8'h04,8'h02,8'hFF,8'h04,8'h00,
        8'h40,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hFF,8'h04,8'h00,
        8'h10,8'h00,8'h00,8'hB0,8'h16};
    localparam logic [7:0] TBL_STOP [22] = '{
        8'h68,8'h10,8'h10,8'h68,8'h00,8'h02,8'h08,8'h32,8'h03,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h01,8'h00,8'h00,8'h00,8'h00,8'h29,8'h69,8'h16};
    localparam logic [7:0] TBL_AFTER [35] = '{
        8'h68,8'h1D,8'h1D,8'h68,8'h00,8'h02,8'h08,8'h32,8'h07,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h0C,8'h00,8'h04,8'h00,8'h01,8'h12,8'h08,8'h12,8'h88,8'h0B,
        8'h01,8'h00,8'h00,8'h00,8'h00,8'hFF,8'h09,8'h00,8'h00,8'h1C,8'h16};

    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        logic [7:0]    data;
    } store_wr_t;

    function automatic logic [5:0] reply_len(input logic [2:0] choice);
        case (choice)
            RP_NEGOTIATE: reply_len = 6'd29;
            RP_RUN:       reply_len = 6'd22;
            RP_STOP:      reply_len = 6'd22;
            RP_READ:      reply_len = 6'd41;
            RP_FORCE:     reply_len = 6'd36;
            RP_AFTER:     reply_len = 6'd35;
            default:      reply_len = 6'd1;
        endcase
    endfunction

    function automatic logic [7:0] reply_rom(input logic [2:0] choice, input logic [5:0] idx);
        logic [7:0] b;
        b = BYTE_ACK;
        case (choice)
            RP_NEGOTIATE: if (idx < 6'd29) b = TBL_NEG[idx[4:0]];
            RP_RUN:       if (idx < 6'd22) b = TBL_RUN[idx[4:0]];
            RP_STOP:      if (idx < 6'd22) b = TBL_STOP[idx[4:0]];
            RP_READ:      if (idx < 6'd41) b = TBL_READ[idx];
            RP_FORCE:     if (idx < 6'd36) b = TBL_FORCE[idx];
            RP_AFTER:     if (idx < 6'd35) b = TBL_AFTER[idx];
            default:      b = BYTE_ACK;
        endcase
        reply_rom = b;
    endfunction

    function automatic logic [3:0] clamp_io(input logic [3:0] v);
        clamp_io = (v > 4'(MAX_IO_BYTES)) ? 4'(MAX_IO_BYTES) : v;
    endfunction

endpackage

`default_nettype wire

/* sv/ppi_if.sv */
// ----------------------------------------------------------------------------
// ppi_if
// Handshake channels of the PPI responder: received words, transmitted words
// and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppi_rx_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic [63:0] plc_outputs;
    modport source (output valid, rx_byte, plc_outputs, input ready);
    modport sink   (input valid, rx_byte, plc_outputs, output ready);
endinterface

interface ppi_tx_if;
    logic        valid;
    logic        ready;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        input_update;
    logic [63:0] input_image;
    modport source (output valid, tx_byte, tx_last, input_update, input_image, input ready);
    modport sink   (input valid, tx_byte, tx_last, input_update, input_image, output ready);
endinterface

interface ppi_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] index;
    logic [3:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/ppi_store.sv */
// ----------------------------------------------------------------------------
// ppi_store
// Frame byte store: one write and one registered read per cycle; entries not
// yet written since reset read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ppi_store
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ppi_pkg::store_wr_t wr,
    input  wire logic [ppi_pkg::AW-1:0] rd_addr,
    output logic [7:0]              rd_data
);
    import ppi_pkg::*;

    logic [7:0]             mem [FRAME_DEPTH];
    logic [FRAME_DEPTH-1:0] vld_reg;
    logic [7:0]             mem_q_reg;
    logic                   rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? mem_q_reg : 8'h00;

endmodule

`default_nettype wire

/* sv/ppi_frame_responder.sv */
// ----------------------------------------------------------------------------
// ppi_frame_responder
// Slave side of a PPI serial link: frames requests and polls, answers with
// canned replies.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : one received word per handshake, with the current PLC output image.
//   tx  : transmitted words; tx_last marks the end of each run.
//   cfg : register writes (index 0 output byte count, 1 input byte count).
// Framing words give no output. The closing word of a request starts eleven
// reads of the frame store (key, two type bytes, eight input image bytes)
// through its single read port, then the acknowledge word if a reply is
// chosen. The closing word of a poll starts a run of 1 to 41 words,
// one per cycle, taken from the reply tables; a read reply splices in the PLC
// bytes and builds its sum on the fly. rx.ready is low during both sequences.
// A stalled tx holds the output register and pauses the sequence; a word that
// gives no output is still taken while a result waits.
// Reset: idle, nothing pending, both counts 1, the frame store reads as zero
// (per-entry valid bits, no clearing pass).
// ----------------------------------------------------------------------------
`default_nettype none

module ppi_frame_responder
(
    input  wire logic clk,
    input  wire logic rst_n,
    ppi_rx_if.sink    rx,
    ppi_tx_if.source  tx,
    ppi_cfg_if.sink   cfg
);
    import ppi_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_REQ  = 2'd2;
    localparam logic [1:0] PH_POLL = 2'd3;

    localparam logic [1:0] S_RX   = 2'd0;
    localparam logic [1:0] S_CLS  = 2'd1;
    localparam logic [1:0] S_ACK  = 2'd2;
    localparam logic [1:0] S_SEND = 2'd3;

    localparam logic [3:0] CLS_LAST = 4'd11;

    logic [1:0]     state_reg, state_next;
    logic [1:0]     phase_reg, phase_next;
    logic [BCW-1:0] bc_reg, bc_next;
    logic [BCW-1:0] flen_reg, flen_next;
    logic [2:0]     pend_reg, pend_next;
    logic [2:0]     send_reg, send_next;
    logic [3:0]     out_cnt_reg, in_cnt_reg;
    logic [3:0]     cls_reg, cls_next;
    logic [5:0]     idx_reg, idx_next;
    logic [7:0]     sum_reg, sum_next;
    logic [63:0]    plc_reg, plc_next;
    logic [7:0]     key_reg, key_next;
    logic [7:0]     b6_reg, b6_next;
    logic [7:0]     b8_reg, b8_next;
    logic [63:0]    img_reg, img_next;

    logic           out_v_reg, out_v_next;
    logic [7:0]     out_b_reg, out_b_next;
    logic           out_l_reg, out_l_next;
    logic           out_u_reg, out_u_next;
    logic [63:0]    out_i_reg, out_i_next;

    store_wr_t      wr;
    logic [AW-1:0]  rd_addr;
    logic [7:0]     rd_data;

    logic           rx_acc;
    logic           slot_free;
    logic [BCW-1:0] bc_inc;
    logic [8:0]     len_sum;
    logic [2:0]     choice;
    logic [3:0]     n_in;
    logic [3:0]     n_out;
    logic [3:0]     img_k;
    logic [5:0]     plc_k;
    logic [7:0]     send_byte;
    logic [5:0]     send_len;

    ppi_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rx.ready  = (state_reg == S_RX);
    assign rx_acc    = rx.valid && rx.ready;
    assign slot_free = !out_v_reg || tx.ready;
    assign cfg.ready = 1'b1;

    assign tx.valid        = out_v_reg;
    assign tx.tx_byte      = out_b_reg;
    assign tx.tx_last      = out_l_reg;
    assign tx.input_update = out_u_reg;
    assign tx.input_image  = out_i_reg;

    assign bc_inc  = bc_reg + BCW'(1);
    assign len_sum = {1'b0, rx.rx_byte} + 9'd6;
    assign n_in    = clamp_io(in_cnt_reg);
    assign n_out   = clamp_io(out_cnt_reg);
    assign img_k   = cls_reg - 4'd4;
    assign plc_k   = idx_reg - READ_SPLICE;
    assign send_len = reply_len(send_reg);

    always_comb
    begin
        choice = RP_NONE;
        if (flen_reg == LEN_NEG && key_reg == BYTE_KEY_NEG)
        begin
            choice = RP_NEGOTIATE;
        end
        else if (flen_reg == LEN_RUN && key_reg == BYTE_KEY_RUN)
        begin
            choice = RP_RUN;
        end
        else if (flen_reg == LEN_STOP && key_reg == BYTE_KEY_RUN)
        begin
            choice = RP_STOP;
        end
        else if (b8_reg == BYTE_B8_READ && b6_reg == BYTE_B6_A)
        begin
            choice = RP_READ;
        end
        else if (b8_reg == BYTE_B8_WR && b6_reg == BYTE_B6_A)
        begin
            choice = RP_FORCE;
        end
        else if (b8_reg == BYTE_B8_WR && b6_reg == BYTE_B6_B)
        begin
            choice = RP_AFTER;
        end
    end

    always_comb
    begin
        send_byte = reply_rom(send_reg, idx_reg);
        if (send_reg == RP_READ)
        begin
            if (idx_reg >= READ_SPLICE && plc_k < {2'b00, n_out})
            begin
                send_byte = plc_reg[8*plc_k[2:0] +: 8];
            end
            else if (idx_reg == READ_SUM)
            begin
                send_byte = sum_reg;
            end
        end
    end

    always_comb
    begin
        case (cls_reg)
            4'd0:    rd_addr = flen_reg[AW-1:0] - AW'(2);
            4'd1:    rd_addr = IDX_B6;
            4'd2:    rd_addr = IDX_B8;
            default: rd_addr = IDX_IMG + AW'(cls_reg - 4'd3);
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        bc_next    = bc_reg;
        flen_next  = flen_reg;
        pend_next  = pend_reg;
        send_next  = send_reg;
        cls_next   = cls_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        plc_next   = plc_reg;
        key_next   = key_reg;
        b6_next    = b6_reg;
        b8_next    = b8_reg;
        img_next   = img_reg;
        out_v_next = out_v_reg && !tx.ready;
        out_b_next = out_b_reg;
        out_l_next = out_l_reg;
        out_u_next = out_u_reg;
        out_i_next = out_i_reg;
        wr.en      = 1'b0;
        wr.addr    = bc_reg[AW-1:0];
        wr.data    = rx.rx_byte;

        case (state_reg)
            S_RX:
            begin
                if (rx_acc)
                begin
                    wr.en   = (bc_reg < BCW'(FRAME_DEPTH));
                    bc_next = bc_inc;
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            wr.en     = 1'b1;
                            wr.addr   = '0;
                            bc_next   = BCW'(1);
                            flen_next = '0;
                            pend_next = RP_NONE;
                            if (rx.rx_byte == BYTE_REQ)
                            begin
                                phase_next = PH_LEN;
                            end
                            else if (rx.rx_byte == BYTE_POLL)
                            begin
                                phase_next = PH_POLL;
                            end
                            else
                            begin
                                bc_next = '0;
                            end
                        end
                        PH_LEN:
                        begin
                            if (len_sum > 9'(FRAME_DEPTH))
                            begin
                                phase_next = PH_IDLE;
                                bc_next    = '0;
                                flen_next  = '0;
                                pend_next  = RP_NONE;
                            end
                            else
                            begin
                                flen_next  = BCW'(len_sum);
                                phase_next = PH_REQ;
                            end
                        end
                        PH_REQ:
                        begin
                            if (bc_inc >= flen_reg)
                            begin
                                bc_next = '0;
                                if (rx.rx_byte == BYTE_END)
                                begin
                                    state_next = S_CLS;
                                    cls_next   = '0;
                                    img_next   = '0;
                                end
                                else
                                begin
                                    phase_next = PH_IDLE;
                                    flen_next  = '0;
                                    pend_next  = RP_NONE;
                                end
                            end
                        end
                        default:
                        begin
                            flen_next = LEN_POLL;
                            if ((bc_reg == '0 && rx.rx_byte != BYTE_POLL) ||
                                (bc_inc >= LEN_POLL))
                            begin
                                phase_next = PH_IDLE;
                                bc_next    = '0;
                                flen_next  = '0;
                                pend_next  = RP_NONE;
                                if (bc_reg != '0 && rx.rx_byte == BYTE_END)
                                begin
                                    state_next = S_SEND;
                                    send_next  = pend_reg;
                                    plc_next   = rx.plc_outputs;
                                    idx_next   = '0;
                                    sum_next   = '0;
                                end
                            end
                        end
                    endcase
                end
            end
            S_CLS:
            begin
                cls_next = cls_reg + 4'd1;
                case (cls_reg)
                    4'd0:    ;
                    4'd1:    key_next = rd_data;
                    4'd2:    b6_next  = rd_data;
                    4'd3:    b8_next  = rd_data;
                    default:
                    begin
                        if (img_k < n_in)
                        begin
                            img_next[8*img_k[2:0] +: 8] = rd_data;
                        end
                    end
                endcase
                if (cls_reg == CLS_LAST)
                begin
                    state_next = S_ACK;
                end
            end
            S_ACK:
            begin
                if (slot_free)
                begin
                    pend_next  = choice;
                    flen_next  = '0;
                    phase_next = PH_POLL;
                    state_next = S_RX;
                    if (choice != RP_NONE)
                    begin
                        out_v_next = 1'b1;
                        out_b_next = BYTE_ACK;
                        out_l_next = 1'b1;
                        out_u_next = (choice == RP_FORCE);
                        out_i_next = (choice == RP_FORCE) ? img_reg : 64'd0;
                    end
                end
            end
            default:
            begin
                if (slot_free)
                begin
                    out_v_next = 1'b1;
                    out_b_next = send_byte;
                    out_l_next = (idx_reg == send_len - 6'd1);
                    out_u_next = 1'b0;
                    out_i_next = 64'd0;
                    idx_next   = idx_reg + 6'd1;
                    if (idx_reg >= SUM_FIRST && idx_reg <= SUM_LAST)
                    begin
                        sum_next = sum_reg + send_byte;
                    end
                    if (idx_reg == send_len - 6'd1)
                    begin
                        state_next = S_RX;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_RX;
            phase_reg   <= PH_IDLE;
            bc_reg      <= '0;
            flen_reg    <= '0;
            pend_reg    <= RP_NONE;
            send_reg    <= RP_NONE;
            cls_reg     <= '0;
            idx_reg     <= '0;
            out_v_reg   <= 1'b0;
            out_cnt_reg <= 4'd1;
            in_cnt_reg  <= 4'd1;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            bc_reg    <= bc_next;
            flen_reg  <= flen_next;
            pend_reg  <= pend_next;
            send_reg  <= send_next;
            cls_reg   <= cls_next;
            idx_reg   <= idx_next;
            out_v_reg <= out_v_next;
            if (cfg.valid && cfg.index == CFG_OUT_COUNT)
            begin
                out_cnt_reg <= cfg.data;
            end
            if (cfg.valid && cfg.index == CFG_IN_COUNT)
            begin
                in_cnt_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        plc_reg   <= plc_next;
        key_reg   <= key_next;
        b6_reg    <= b6_next;
        b8_reg    <= b8_next;
        img_reg   <= img_next;
        out_b_reg <= out_b_next;
        out_l_reg <= out_l_next;
        out_u_reg <= out_u_next;
        out_i_reg <= out_i_next;
    end

`ifndef SYNTHESIS
    a_pend_poll: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != RP_NONE |-> phase_reg == PH_POLL)
        else $error("reply pending outside poll phase");
    a_bc_range: assert property (@(posedge clk) disable iff (!rst_n)
        bc_reg <= BCW'(FRAME_DEPTH))
        else $error("byte count beyond frame depth");
    a_cls_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLS || state_reg == S_ACK) |-> phase_reg == PH_REQ)
        else $error("classification outside request phase");
    a_send_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEND |-> idx_reg < send_len)
        else $error("reply index past reply length");
`endif

endmodule

`default_nettype wire
